// ===== hdl/rac_pkg.sv =====
// Shared constants and types for the range assign / range count unit.
`default_nettype none

package rac_pkg;

   localparam int POSITIONS = 1024;
   localparam int POS_W     = 10;
   localparam int CNT_W     = 11;
   localparam int CMD_W     = 2;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int WORDS     = POSITIONS / WORD_W;
   localparam int ADDR_W    = $clog2(WORDS);
   localparam int POP_W     = BIT_W + 1;

   localparam logic [CMD_W-1:0] CMD_WAKE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

   // Per-word control from the sequencer to the word operator.
   typedef struct packed {
      logic              mark;      // value written by wake or sleep
      logic              first;     // word holds the low end of the range
      logic              last;      // word holds the high end of the range
      logic [BIT_W-1:0]  lo_bit;
      logic [BIT_W-1:0]  hi_bit;
   } word_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/rac_mark_ram.sv =====
// Mark store: one 32-bit word of awake marks per entry, registered read.
`default_nettype none

module rac_mark_ram (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [rac_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [rac_pkg::WORD_W-1:0]  rd_data,
   input  wire logic                        wr_en,
   input  wire logic [rac_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [rac_pkg::WORD_W-1:0]  wr_data
);

   logic [rac_pkg::WORD_W-1:0] mem [rac_pkg::WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rac_word_op.sv =====
// Word operator: range mask, wake/sleep update and awake count for one word.
`default_nettype none

module rac_word_op (
   input  wire rac_pkg::word_ctl_type       ctl,
   input  wire logic [rac_pkg::WORD_W-1:0]  word_in,
   output logic      [rac_pkg::WORD_W-1:0]  word_out,
   output logic      [rac_pkg::POP_W-1:0]   ones
);

   logic [rac_pkg::WORD_W-1:0] lo_mask;
   logic [rac_pkg::WORD_W-1:0] hi_mask;
   logic [rac_pkg::WORD_W-1:0] mask;
   logic [rac_pkg::WORD_W-1:0] hits;

   always_comb begin
      lo_mask = ctl.first ? ({rac_pkg::WORD_W{1'b1}} << ctl.lo_bit) : {rac_pkg::WORD_W{1'b1}};
      hi_mask = ctl.last
         ? ({rac_pkg::WORD_W{1'b1}} >> (rac_pkg::BIT_W'(rac_pkg::WORD_W - 1) - ctl.hi_bit))
         : {rac_pkg::WORD_W{1'b1}};
      mask = lo_mask & hi_mask;
      word_out = ctl.mark ? (word_in | mask) : (word_in & ~mask);
      hits = word_in & mask;
   end

   always_comb begin
      ones = '0;
      for (int i = 0; i < rac_pkg::WORD_W; i++) begin
         ones = ones + rac_pkg::POP_W'(hits[i]);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/range_assign_range_count_unit.sv =====
// Top level: request sequencer, word walk over the mark store, result register.
//
//   channel   ports                                        direction
//   request   req_valid/req_stall, command, range_low/high in
//   result    rsp_valid/rsp_stall, awake_count             out
//   csr       csr_wr_en, csr_wr_data (active_count)        in
//
// A request walks the 32-bit mark words its range touches, one word per cycle
// through the registered-read memory.
// Synchronous reset; every mark reads awake until its word is first written,
// tracked by one valid flop per word, so no clearing pass is needed.
// Results sit in an output register; a held result stalls only the next count's finish.
`default_nettype none

module range_assign_range_count_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [rac_pkg::CMD_W-1:0]  req_command,
   input  wire logic [rac_pkg::POS_W-1:0]  req_range_low,
   input  wire logic [rac_pkg::POS_W-1:0]  req_range_high,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [rac_pkg::CNT_W-1:0]  rsp_awake_count,
   input  wire logic                       csr_wr_en,
   input  wire logic [rac_pkg::CNT_W-1:0]  csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [rac_pkg::CNT_W-1:0]    active_ff, active_in;
   logic [rac_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [rac_pkg::POS_W-1:0]    lo_ff, lo_in;
   logic [rac_pkg::POS_W-1:0]    hi_ff, hi_in;
   logic [rac_pkg::ADDR_W-1:0]   cur_ff, cur_in;
   logic                         pipe_valid_ff, pipe_valid_in;
   logic [rac_pkg::ADDR_W-1:0]   pipe_addr_ff, pipe_addr_in;
   logic [rac_pkg::CNT_W-1:0]    sum_ff, sum_in;
   logic [rac_pkg::WORDS-1:0]    word_valid_ff, word_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rac_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [rac_pkg::CNT_W-1:0]    limit;
   logic                         range_ok;
   logic [rac_pkg::POS_W-1:0]    eff_hi;
   logic                         accept;
   logic                         rd_en;
   logic [rac_pkg::WORD_W-1:0]   rd_data;
   logic [rac_pkg::WORD_W-1:0]   word_in;
   logic [rac_pkg::WORD_W-1:0]   word_out;
   logic [rac_pkg::POP_W-1:0]    ones;
   logic                         wr_en;
   rac_pkg::word_ctl_type        ctl;

   assign req_stall       = (state_ff != ST_IDLE);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_awake_count = rsp_count_ff;

   // Clip the range to positions in use.
   always_comb begin
      limit = (active_ff > rac_pkg::CNT_W'(rac_pkg::POSITIONS))
         ? rac_pkg::CNT_W'(rac_pkg::POSITIONS) : active_ff;
      range_ok = (req_range_low <= req_range_high)
         && ({1'b0, req_range_low} < limit);
      eff_hi = ({1'b0, req_range_high} < limit)
         ? req_range_high : rac_pkg::POS_W'(limit - rac_pkg::CNT_W'(1));
   end

   assign ctl.mark   = (cmd_ff == rac_pkg::CMD_WAKE);
   assign ctl.first  = (pipe_addr_ff == lo_ff[rac_pkg::POS_W-1:rac_pkg::BIT_W]);
   assign ctl.last   = (pipe_addr_ff == hi_ff[rac_pkg::POS_W-1:rac_pkg::BIT_W]);
   assign ctl.lo_bit = lo_ff[rac_pkg::BIT_W-1:0];
   assign ctl.hi_bit = hi_ff[rac_pkg::BIT_W-1:0];

   // Words never written still read as all awake.
   assign word_in = word_valid_ff[pipe_addr_ff] ? rd_data : {rac_pkg::WORD_W{1'b1}};
   assign wr_en   = pipe_valid_ff && (cmd_ff != rac_pkg::CMD_COUNT);
   assign rd_en   = (state_ff == ST_WALK);

   rac_mark_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (cur_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (pipe_addr_ff),
      .wr_data (word_out)
   );

   rac_word_op u_word_op (
      .ctl      (ctl),
      .word_in  (word_in),
      .word_out (word_out),
      .ones     (ones)
   );

   always_comb begin
      state_in      = state_ff;
      active_in     = csr_wr_en ? csr_wr_data : active_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      pipe_valid_in = 1'b0;
      pipe_addr_in  = cur_ff;
      sum_in        = sum_ff;
      word_valid_in = word_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;

      if (pipe_valid_ff) begin
         sum_in = sum_ff + rac_pkg::CNT_W'(ones);
         if (wr_en) begin
            word_valid_in[pipe_addr_ff] = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               lo_in  = req_range_low;
               hi_in  = eff_hi;
               cur_in = req_range_low[rac_pkg::POS_W-1:rac_pkg::BIT_W];
               sum_in = '0;
               case (req_command)
                  rac_pkg::CMD_WAKE, rac_pkg::CMD_SLEEP: begin
                     if (range_ok) begin
                        state_in = ST_WALK;
                     end
                  end
                  rac_pkg::CMD_COUNT: begin
                     state_in = range_ok ? ST_WALK : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            pipe_valid_in = 1'b1;
            pipe_addr_in  = cur_ff;
            if (cur_ff == hi_ff[rac_pkg::POS_W-1:rac_pkg::BIT_W]) begin
               state_in = ST_DRAIN;
            end else begin
               cur_in = cur_ff + rac_pkg::ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (cmd_ff != rac_pkg::CMD_COUNT) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = sum_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= rac_pkg::CNT_W'(1024);
         pipe_valid_ff <= 1'b0;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pipe_valid_ff <= pipe_valid_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cur_ff       <= cur_in;
      pipe_addr_ff <= pipe_addr_in;
      sum_ff       <= sum_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire
